// ===== rtl/mcrg_pkg.sv =====
`default_nettype none

package mcrg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MCU_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MCU_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MCUS_PER_ROW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MCUS_PER_COL = 3'd5;

    localparam int RST_OUT_WIDTH    = 96;
    localparam int RST_OUT_HEIGHT   = 96;
    localparam int RST_MCU_WIDTH    = 16;
    localparam int RST_MCU_HEIGHT   = 8;
    localparam int RST_MCUS_PER_ROW = 10;
    localparam int RST_MCUS_PER_COL = 15;

    // first MCU index beyond the input range; window stop saturates here
    localparam int BLOCK_LIMIT = 256;

    localparam int LUM_W = 24;
    localparam int POS_W = 14;
    localparam int IDX_W = 20;

    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46871;
    localparam logic [15:0] COEF_B = 16'd4732;

    typedef struct packed {
        logic [7:0]  block_col;
        logic [7:0]  block_row;
        logic [3:0]  pixel_row;
        logic [3:0]  pixel_col;
        logic [15:0] rgb_pixel;
    } t_in_item;

    typedef struct packed {
        logic [19:0] pixel_index;
        logic [7:0]  gray_level;
    } t_out_item;

    typedef struct packed {
        logic [7:0] start;
        logic [8:0] stop;
    } t_window;

endpackage

`default_nettype wire

// ===== rtl/mcu_crop_rgb565_to_gray.sv =====
`default_nettype none

// A kept item passes through the stage 1, stage 2 and output registers before it shows on o_item.
// Throughput: one item per cycle while busy is low, in a three-stage pipeline; no receiver stall.
// A configuration write recomputes the crop window with a bit-serial divider:
// busy is high and o_cfg_ready low while r_go is set and until both dividers return to idle.
// Reset (synchronous, active low) loads default registers and their window, empties the pipe.
module mcu_crop_rgb565_to_gray #(
    parameter int MAX_SIDE = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire mcrg_pkg::t_in_item               i_item,
    output logic                                  o_valid,
    output mcrg_pkg::t_out_item                   o_item,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [mcrg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [mcrg_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int PROD_W = mcrg_pkg::POS_W + SIDE_W + 1;

    localparam int RST_W   = (MAX_SIDE < mcrg_pkg::RST_OUT_WIDTH)
                           ? MAX_SIDE : mcrg_pkg::RST_OUT_WIDTH;
    localparam int RST_H   = (MAX_SIDE < mcrg_pkg::RST_OUT_HEIGHT)
                           ? MAX_SIDE : mcrg_pkg::RST_OUT_HEIGHT;
    localparam int RST_KX  = RST_W / mcrg_pkg::RST_MCU_WIDTH;
    localparam int RST_KY  = RST_H / mcrg_pkg::RST_MCU_HEIGHT;
    localparam int RST_SX  = (RST_KX > mcrg_pkg::RST_MCUS_PER_ROW)
                           ? 0 : (mcrg_pkg::RST_MCUS_PER_ROW - RST_KX) / 2;
    localparam int RST_SY  = (RST_KY > mcrg_pkg::RST_MCUS_PER_COL)
                           ? 0 : (mcrg_pkg::RST_MCUS_PER_COL - RST_KY) / 2;
    localparam int RST_EX  = (RST_SX + RST_KX > mcrg_pkg::BLOCK_LIMIT)
                           ? mcrg_pkg::BLOCK_LIMIT : RST_SX + RST_KX;
    localparam int RST_EY  = (RST_SY + RST_KY > mcrg_pkg::BLOCK_LIMIT)
                           ? mcrg_pkg::BLOCK_LIMIT : RST_SY + RST_KY;

    // configuration
    logic [10:0] r_out_width;
    logic [10:0] r_out_height;
    logic [4:0]  r_mcu_width;
    logic [4:0]  r_mcu_height;
    logic [8:0]  r_mcus_per_row;
    logic [8:0]  r_mcus_per_col;
    logic        r_go;

    logic              n_cfg_wr;
    logic              n_accept;
    logic [SIDE_W-1:0] n_side_x;
    logic [SIDE_W-1:0] n_side_y;
    logic              win_x_busy;
    logic              win_y_busy;
    mcrg_pkg::t_window win_x;
    mcrg_pkg::t_window win_y;

    assign n_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !(win_x_busy || win_y_busy || r_go);
    assign busy        = !o_cfg_ready;
    assign n_accept    = start && !busy;

    assign n_side_x = (32'(r_out_width) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                        : SIDE_W'(r_out_width);
    assign n_side_y = (32'(r_out_height) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                         : SIDE_W'(r_out_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width    <= 11'(mcrg_pkg::RST_OUT_WIDTH);
            r_out_height   <= 11'(mcrg_pkg::RST_OUT_HEIGHT);
            r_mcu_width    <= 5'(mcrg_pkg::RST_MCU_WIDTH);
            r_mcu_height   <= 5'(mcrg_pkg::RST_MCU_HEIGHT);
            r_mcus_per_row <= 9'(mcrg_pkg::RST_MCUS_PER_ROW);
            r_mcus_per_col <= 9'(mcrg_pkg::RST_MCUS_PER_COL);
            r_go           <= 1'b0;
        end else begin
            r_go <= n_cfg_wr;
            if (n_cfg_wr) begin
                case (i_cfg_index)
                    mcrg_pkg::CFG_OUT_WIDTH:    r_out_width    <= i_cfg_data;
                    mcrg_pkg::CFG_OUT_HEIGHT:   r_out_height   <= i_cfg_data;
                    mcrg_pkg::CFG_MCU_WIDTH:    r_mcu_width    <= i_cfg_data[4:0];
                    mcrg_pkg::CFG_MCU_HEIGHT:   r_mcu_height   <= i_cfg_data[4:0];
                    mcrg_pkg::CFG_MCUS_PER_ROW: r_mcus_per_row <= i_cfg_data[8:0];
                    mcrg_pkg::CFG_MCUS_PER_COL: r_mcus_per_col <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    mcrg_window #(
        .SIDE_W    (SIDE_W),
        .RST_START (RST_SX),
        .RST_STOP  (RST_EX)
    ) u_win_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (r_go),
        .i_side   (n_side_x),
        .i_msize  (r_mcu_width),
        .i_mcount (r_mcus_per_row),
        .o_busy   (win_x_busy),
        .o_win    (win_x)
    );

    mcrg_window #(
        .SIDE_W    (SIDE_W),
        .RST_START (RST_SY),
        .RST_STOP  (RST_EY)
    ) u_win_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (r_go),
        .i_side   (n_side_y),
        .i_msize  (r_mcu_height),
        .i_mcount (r_mcus_per_col),
        .o_busy   (win_y_busy),
        .o_win    (win_y)
    );

    // stage 1: window test, MCU offsets, color products
    logic                       n_keep;
    logic [7:0]                 n_r8;
    logic [7:0]                 n_g8;
    logic [7:0]                 n_b8;
    logic                       r_v1;
    logic [7:0]                 r_dx1;
    logic [7:0]                 r_dy1;
    logic [3:0]                 r_pcol1;
    logic [3:0]                 r_prow1;
    logic [mcrg_pkg::LUM_W-1:0] r_pr1;
    logic [mcrg_pkg::LUM_W-1:0] r_pg1;
    logic [mcrg_pkg::LUM_W-1:0] r_pb1;

    always_comb begin
        n_keep = ({1'b0, i_item.pixel_col} < r_mcu_width)
              && ({1'b0, i_item.pixel_row} < r_mcu_height)
              && (i_item.block_col >= win_x.start)
              && ({1'b0, i_item.block_col} < win_x.stop)
              && (i_item.block_row >= win_y.start)
              && ({1'b0, i_item.block_row} < win_y.stop);
        n_r8 = {i_item.rgb_pixel[15:11], 3'b000};
        n_g8 = {i_item.rgb_pixel[10:5], 2'b00};
        n_b8 = {i_item.rgb_pixel[4:0], 3'b000};
    end

    // stage 2: pixel coordinates, luminance sum
    logic [mcrg_pkg::POS_W-1:0] n_x2;
    logic [mcrg_pkg::POS_W-1:0] n_y2;
    logic [mcrg_pkg::LUM_W-1:0] n_sum2;
    logic                       r_v2;
    logic [mcrg_pkg::POS_W-1:0] r_x2;
    logic [mcrg_pkg::POS_W-1:0] r_y2;
    logic [7:0]                 r_gray2;

    always_comb begin
        n_x2 = mcrg_pkg::POS_W'(r_dx1) * mcrg_pkg::POS_W'(r_mcu_width)
             + mcrg_pkg::POS_W'(r_pcol1);
        n_y2 = mcrg_pkg::POS_W'(r_dy1) * mcrg_pkg::POS_W'(r_mcu_height)
             + mcrg_pkg::POS_W'(r_prow1);
        n_sum2 = r_pr1 + r_pg1 + r_pb1;
    end

    // stage 3: flat index
    logic [PROD_W-1:0] n_idx3;
    logic              r_valid;
    mcrg_pkg::t_out_item r_out;

    assign n_idx3 = PROD_W'(r_y2) * PROD_W'(n_side_x) + PROD_W'(r_x2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= n_accept && n_keep;
            r_v2    <= r_v1;
            r_valid <= r_v2;
        end
        r_dx1   <= i_item.block_col - win_x.start;
        r_dy1   <= i_item.block_row - win_y.start;
        r_pcol1 <= i_item.pixel_col;
        r_prow1 <= i_item.pixel_row;
        r_pr1   <= mcrg_pkg::LUM_W'(mcrg_pkg::COEF_R) * mcrg_pkg::LUM_W'(n_r8);
        r_pg1   <= mcrg_pkg::LUM_W'(mcrg_pkg::COEF_G) * mcrg_pkg::LUM_W'(n_g8);
        r_pb1   <= mcrg_pkg::LUM_W'(mcrg_pkg::COEF_B) * mcrg_pkg::LUM_W'(n_b8);
        r_x2    <= n_x2;
        r_y2    <= n_y2;
        r_gray2 <= n_sum2[23:16];
        r_out   <= '{pixel_index: n_idx3[mcrg_pkg::IDX_W-1:0], gray_level: r_gray2};
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_cfg_recompute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> busy)
        else $error("window recompute not started after config write");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without an accepted item");

    a_gray_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.gray_level <= 8'd250))
        else $error("luminance out of range");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (win_x_busy || win_y_busy) |-> !n_accept)
        else $error("item accepted during window recompute");
`endif

endmodule

`default_nettype wire

// ===== rtl/mcrg_window.sv =====
`default_nettype none

module mcrg_window #(
    parameter int SIDE_W    = 11,
    parameter int RST_START = 0,
    parameter int RST_STOP  = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_go,
    input  wire [SIDE_W-1:0]     i_side,
    input  wire [4:0]            i_msize,
    input  wire [8:0]            i_mcount,
    output logic                 o_busy,
    output mcrg_pkg::t_window    o_win
);

    localparam int CNT_W = $clog2(SIDE_W);
    localparam int CMP_W = (SIDE_W > 9) ? SIDE_W : 9;
    localparam int SUM_W = CMP_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [SIDE_W-1:0]  r_quo;
    logic [5:0]         r_rem;
    mcrg_pkg::t_window  r_win;

    logic [5:0]         n_rem_sh;
    logic               n_bit;
    logic [5:0]         n_rem;
    logic [SIDE_W-1:0]  n_keep;
    logic [CMP_W-1:0]   n_diff;
    logic [7:0]         n_start;
    logic [SUM_W-1:0]   n_stop_full;
    logic [8:0]         n_stop;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_rem_sh = {r_rem[4:0], r_quo[SIDE_W-1]};
        n_bit    = (n_rem_sh >= {1'b0, i_msize});
        n_rem    = n_bit ? (n_rem_sh - {1'b0, i_msize}) : n_rem_sh;
    end

    always_comb begin
        n_keep = (i_msize == 5'd0) ? '0 : r_quo;
        if (CMP_W'(n_keep) > CMP_W'(i_mcount)) begin
            n_diff = '0;
        end else begin
            n_diff = CMP_W'(i_mcount) - CMP_W'(n_keep);
        end
        n_start     = 8'(n_diff >> 1);
        n_stop_full = SUM_W'(n_start) + SUM_W'(n_keep);
        n_stop      = (n_stop_full > SUM_W'(mcrg_pkg::BLOCK_LIMIT))
                    ? 9'(mcrg_pkg::BLOCK_LIMIT) : n_stop_full[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_win   <= '{start: 8'(RST_START), stop: 9'(RST_STOP)};
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_go) begin
                        r_quo   <= i_side;
                        r_rem   <= '0;
                        r_count <= CNT_W'(SIDE_W - 1);
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    r_rem   <= n_rem;
                    r_quo   <= {r_quo[SIDE_W-2:0], n_bit};
                    r_count <= r_count - 1'b1;
                    if (r_count == '0) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    r_win   <= '{start: n_start, stop: n_stop};
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_win  = r_win;

endmodule

`default_nettype wire

// ===== bench/gray_crop_checker.sv =====
`timescale 1ns / 100ps

module gray_crop_checker #(
    parameter int MAX_SIDE = 1024
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    input  wire                                 busy,
    input  mcrg_pkg::t_in_item                  i_item,
    input  wire                                 o_valid,
    input  mcrg_pkg::t_out_item                 o_item,
    input  wire                                 i_cfg_valid,
    input  wire                                 o_cfg_ready,
    input  wire [mcrg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [mcrg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int unsigned                         o_pending,
    output int unsigned                         o_mismatches
);

    int unsigned         width_reg;
    int unsigned         height_reg;
    int unsigned         mcu_w_reg;
    int unsigned         mcu_h_reg;
    int unsigned         mcus_row_reg;
    int unsigned         mcus_col_reg;
    int unsigned         mismatches = 0;
    mcrg_pkg::t_out_item gray_pixels_due[$];
    mcrg_pkg::t_out_item due;
    mcrg_pkg::t_out_item guess;

    function automatic bit predict_gray_pixel(input mcrg_pkg::t_in_item px,
                                              output mcrg_pkg::t_out_item res);
        int unsigned w, h, kx, ky, sx, sy, x, y, lum, bc, br, pr, pc;
        res = '0;
        bc = 32'(px.block_col);
        br = 32'(px.block_row);
        pr = 32'(px.pixel_row);
        pc = 32'(px.pixel_col);
        w  = (width_reg > MAX_SIDE) ? MAX_SIDE : width_reg;
        h  = (height_reg > MAX_SIDE) ? MAX_SIDE : height_reg;
        kx = (mcu_w_reg == 0) ? 0 : w / mcu_w_reg;
        ky = (mcu_h_reg == 0) ? 0 : h / mcu_h_reg;
        sx = (kx > mcus_row_reg) ? 0 : (mcus_row_reg - kx) / 2;
        sy = (ky > mcus_col_reg) ? 0 : (mcus_col_reg - ky) / 2;
        if (pc >= mcu_w_reg || pr >= mcu_h_reg)
            return 1'b0;
        if (bc < sx || bc >= sx + kx)
            return 1'b0;
        if (br < sy || br >= sy + ky)
            return 1'b0;
        x = (bc - sx) * mcu_w_reg + pc;
        y = (br - sy) * mcu_h_reg + pr;
        lum = 32'd13933 * 32'({px.rgb_pixel[15:11], 3'b000})
            + 32'd46871 * 32'({px.rgb_pixel[10:5], 2'b00})
            + 32'd4732 * 32'({px.rgb_pixel[4:0], 3'b000});
        res.pixel_index = 20'(y * w + x);
        res.gray_level  = 8'(lum >> 16);
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input mcrg_pkg::t_out_item want,
                                 input mcrg_pkg::t_out_item got);
        if (mismatches < 10)
            $display("%0t gray crop %s: expected index %0d gray %0d, got index %0d gray %0d",
                     $time, what, want.pixel_index, want.gray_level,
                     got.pixel_index, got.gray_level);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg    = mcrg_pkg::RST_OUT_WIDTH;
            height_reg   = mcrg_pkg::RST_OUT_HEIGHT;
            mcu_w_reg    = mcrg_pkg::RST_MCU_WIDTH;
            mcu_h_reg    = mcrg_pkg::RST_MCU_HEIGHT;
            mcus_row_reg = mcrg_pkg::RST_MCUS_PER_ROW;
            mcus_col_reg = mcrg_pkg::RST_MCUS_PER_COL;
            gray_pixels_due.delete();
        end else begin
            if (o_valid) begin
                if (gray_pixels_due.size() == 0) begin
                    note_mismatch("unexpected item", '0, o_item);
                end else begin
                    due = gray_pixels_due.pop_front();
                    if (due.pixel_index != o_item.pixel_index
                        || due.gray_level != o_item.gray_level)
                        note_mismatch("wrong item", due, o_item);
                end
            end
            if (start && !busy) begin
                if (predict_gray_pixel(i_item, guess))
                    gray_pixels_due.push_back(guess);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mcrg_pkg::CFG_OUT_WIDTH:    width_reg    = 32'(i_cfg_data);
                    mcrg_pkg::CFG_OUT_HEIGHT:   height_reg   = 32'(i_cfg_data);
                    mcrg_pkg::CFG_MCU_WIDTH:    mcu_w_reg    = 32'(i_cfg_data[4:0]);
                    mcrg_pkg::CFG_MCU_HEIGHT:   mcu_h_reg    = 32'(i_cfg_data[4:0]);
                    mcrg_pkg::CFG_MCUS_PER_ROW: mcus_row_reg = 32'(i_cfg_data[8:0]);
                    mcrg_pkg::CFG_MCUS_PER_COL: mcus_col_reg = 32'(i_cfg_data[8:0]);
                    default: ;
                endcase
            end
        end
        o_pending    <= gray_pixels_due.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== bench/mcu_crop_rgb565_to_gray_tb.sv =====
`timescale 1ns / 100ps

module mcu_crop_rgb565_to_gray_tb;

    localparam int MAX_SIDE    = 1024;
    localparam int CYCLE_LIMIT = 400000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    mcrg_pkg::t_in_item              i_item = '0;
    logic                            o_valid;
    mcrg_pkg::t_out_item             o_item;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [mcrg_pkg::CFG_IDX_W-1:0]  i_cfg_index = mcrg_pkg::CFG_OUT_WIDTH;
    logic [mcrg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;

    // window as last written, used only to aim the stimulus
    int unsigned crop_w = mcrg_pkg::RST_OUT_WIDTH;
    int unsigned crop_h = mcrg_pkg::RST_OUT_HEIGHT;
    int unsigned mcu_w = mcrg_pkg::RST_MCU_WIDTH;
    int unsigned mcu_h = mcrg_pkg::RST_MCU_HEIGHT;
    int unsigned mcus_row = mcrg_pkg::RST_MCUS_PER_ROW;
    int unsigned mcus_col = mcrg_pkg::RST_MCUS_PER_COL;

    mcu_crop_rgb565_to_gray #(
        .MAX_SIDE(MAX_SIDE)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_valid(o_valid),
        .o_item(o_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    gray_crop_checker #(
        .MAX_SIDE(MAX_SIDE)
    ) gray_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_valid(o_valid),
        .o_item(o_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_pending(pending),
        .o_mismatches(mismatches)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("mcu_crop_rgb565_to_gray_tb NOT OK");
            $finish;
        end
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void crop_span(input int unsigned side, input int unsigned msize,
                                      input int unsigned mcount, output int unsigned first,
                                      output int unsigned keep);
        int unsigned s;
        s     = (side > MAX_SIDE) ? MAX_SIDE : side;
        keep  = (msize == 0) ? 0 : s / msize;
        first = (keep > mcount) ? 0 : (mcount - keep) / 2;
    endfunction

    task automatic send_pixel(input logic [7:0] bc, input logic [7:0] br,
                              input logic [3:0] pr, input logic [3:0] pc,
                              input logic [15:0] rgb);
        int unsigned g;
        i_item <= '{block_col: bc, block_row: br, pixel_row: pr, pixel_col: pc,
                    rgb_pixel: rgb};
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        g = idle_gap();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // block drained: nothing due, pipeline flushed of dropped items too
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mcrg_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        int unsigned g;
        i_cfg_index <= idx;
        i_cfg_data  <= mcrg_pkg::CFG_DATA_W'(val);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        g = idle_gap();
        if (g > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic set_crop(input int unsigned ow, input int unsigned oh,
                            input int unsigned mw, input int unsigned mh,
                            input int unsigned mr, input int unsigned mc);
        settle();
        write_reg(mcrg_pkg::CFG_OUT_WIDTH, ow);
        write_reg(mcrg_pkg::CFG_OUT_HEIGHT, oh);
        write_reg(mcrg_pkg::CFG_MCU_WIDTH, mw);
        write_reg(mcrg_pkg::CFG_MCU_HEIGHT, mh);
        write_reg(mcrg_pkg::CFG_MCUS_PER_ROW, mr);
        write_reg(mcrg_pkg::CFG_MCUS_PER_COL, mc);
        if (i_cfg_valid)
            i_cfg_valid <= 1'b0;
        crop_w   = ow;
        crop_h   = oh;
        mcu_w    = mw;
        mcu_h    = mh;
        mcus_row = mr;
        mcus_col = mc;
    endtask

    task automatic random_crop();
        int unsigned r, ow, oh, mw, mh, mr, mc;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            mw = ($urandom_range(0, 1) != 0) ? 8 << $urandom_range(0, 1) : $urandom_range(1, 16);
            mh = ($urandom_range(0, 1) != 0) ? 8 << $urandom_range(0, 1) : $urandom_range(1, 16);
            mr = $urandom_range(1, 40);
            mc = $urandom_range(1, 40);
            ow = mw * $urandom_range(1, mr + 2) + $urandom_range(0, mw - 1);
            oh = mh * $urandom_range(1, mc + 2) + $urandom_range(0, mh - 1);
        end else if (r < 8) begin
            ow = $urandom_range(0, 2047);
            oh = $urandom_range(0, 2047);
            mw = $urandom_range(0, 31);
            mh = $urandom_range(0, 31);
            mr = $urandom_range(0, 511);
            mc = $urandom_range(0, 511);
        end else begin
            ow = ($urandom_range(0, 1) != 0) ? 1024 : (($urandom_range(0, 1) != 0) ? 2047 : 1);
            oh = ($urandom_range(0, 1) != 0) ? 1024 : (($urandom_range(0, 1) != 0) ? 2047 : 1);
            mw = ($urandom_range(0, 1) != 0) ? 16 : (($urandom_range(0, 1) != 0) ? 1 : 31);
            mh = ($urandom_range(0, 1) != 0) ? 16 : (($urandom_range(0, 1) != 0) ? 1 : 31);
            mr = ($urandom_range(0, 1) != 0) ? 511 : (($urandom_range(0, 1) != 0) ? 1 : 256);
            mc = ($urandom_range(0, 1) != 0) ? 511 : (($urandom_range(0, 1) != 0) ? 1 : 256);
        end
        set_crop(ow, oh, mw, mh, mr, mc);
    endtask

    // mostly pixels aimed inside the window, the rest noise and window edges
    task automatic random_pixel();
        int unsigned sx, kx, sy, ky, r;
        logic [7:0]  bc, br;
        logic [3:0]  pr, pc;
        logic [15:0] rgb;
        crop_span(crop_w, mcu_w, mcus_row, sx, kx);
        crop_span(crop_h, mcu_h, mcus_col, sy, ky);
        bc  = 8'($urandom);
        br  = 8'($urandom);
        pr  = 4'($urandom);
        pc  = 4'($urandom);
        rgb = ($urandom_range(0, 9) != 0) ? 16'($urandom) :
              (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
        r = $urandom_range(0, 99);
        if (r < 90) begin
            if (kx > 0)
                bc = (r < 80) ? 8'($urandom_range(sx, (sx + kx > 256) ? 255 : sx + kx - 1))
                              : (($urandom_range(0, 1) != 0) ? 8'(sx - 1) : 8'(sx + kx));
            if (ky > 0)
                br = 8'($urandom_range(sy, (sy + ky > 256) ? 255 : sy + ky - 1));
            if (mcu_w >= 1 && mcu_w <= 16)
                pc = 4'($urandom_range(0, mcu_w - 1));
            if (mcu_h >= 1 && mcu_h <= 16)
                pr = 4'($urandom_range(0, mcu_h - 1));
        end
        send_pixel(bc, br, pr, pc, rgb);
    endtask

    initial begin
        int unsigned phase_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window: MCU columns 2..7, rows 1..12
        send_pixel(8'd2, 8'd1, 4'd0, 4'd0, 16'h0000);
        send_pixel(8'd7, 8'd12, 4'd7, 4'd15, 16'hFFFF);
        send_pixel(8'd4, 8'd5, 4'd3, 4'd9, 16'hF800);
        send_pixel(8'd5, 8'd6, 4'd2, 4'd1, 16'h07E0);
        send_pixel(8'd6, 8'd7, 4'd5, 4'd12, 16'h001F);
        send_pixel(8'd3, 8'd3, 4'd8, 4'd0, 16'hFFFF);
        send_pixel(8'd3, 8'd3, 4'd15, 4'd15, 16'hFFFF);
        send_pixel(8'd1, 8'd5, 4'd0, 4'd0, 16'hFFFF);
        send_pixel(8'd8, 8'd5, 4'd0, 4'd0, 16'hFFFF);
        send_pixel(8'd3, 8'd0, 4'd0, 4'd0, 16'hFFFF);
        send_pixel(8'd3, 8'd13, 4'd0, 4'd0, 16'hFFFF);
        send_pixel(8'd255, 8'd255, 4'd15, 4'd15, 16'hFFFF);

        // crop wider than frame: start stays at zero, top index reached
        set_crop(1024, 1024, 16, 16, 1, 1);
        send_pixel(8'd63, 8'd63, 4'd15, 4'd15, 16'hFFFF);
        send_pixel(8'd64, 8'd0, 4'd0, 4'd0, 16'hFFFF);
        send_pixel(8'd0, 8'd0, 4'd0, 4'd0, 16'h5A5A);

        // oversized output clipped to the max side
        set_crop(2047, 2047, 16, 16, 511, 511);
        send_pixel(8'd223, 8'd223, 4'd0, 4'd0, 16'h1234);
        send_pixel(8'd255, 8'd255, 4'd15, 4'd15, 16'hFFFF);
        send_pixel(8'd222, 8'd230, 4'd0, 4'd0, 16'hFFFF);

        // zero MCU size on either axis keeps nothing
        set_crop(96, 96, 0, 8, 10, 15);
        send_pixel(8'd4, 8'd5, 4'd0, 4'd0, 16'hFFFF);
        set_crop(96, 96, 16, 0, 10, 15);
        send_pixel(8'd4, 8'd5, 4'd0, 4'd0, 16'hFFFF);

        set_crop(1, 1, 1, 1, 1, 1);
        send_pixel(8'd0, 8'd0, 4'd0, 4'd0, 16'hFFFF);
        send_pixel(8'd0, 8'd0, 4'd0, 4'd1, 16'hFFFF);

        for (int p = 0; p < 22; p++) begin
            quiet = ($urandom_range(0, 3) == 0);
            random_crop();
            phase_items = $urandom_range(30, 70);
            repeat (phase_items) random_pixel();
        end
        settle();

        if (mismatches == 0 && pending == 0) begin
            $display("mcu_crop_rgb565_to_gray_tb OK");
        end else begin
            $display("mcu_crop_rgb565_to_gray_tb NOT OK");
        end
        $finish;
    end

endmodule
